>>> hw/rtl/mtm_pkg.sv
package mtm_pkg;

   localparam int QueueDepthDefault = 64;
   localparam logic [31:0] EagerLimitReset = 32'd65535;

   typedef enum logic [1:0] {
      ST_MATCHED = 2'd0,
      ST_QUEUED  = 2'd1,
      ST_DROPPED = 2'd2
   } status_type;

   localparam logic OP_RECV = 1'b0;
   localparam logic OP_MSG  = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [11:0] peer_rank;
      logic        peer_any;
      logic [15:0] msg_tag;
      logic        tag_any;
      logic [31:0] msg_size;
      logic [31:0] op_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] hit_rank;
      logic [15:0] hit_tag;
      logic [31:0] hit_size;
      logic [31:0] hit_handle;
      logic [6:0]  search_count;
      logic        rendezvous;
   } rsp_type;

   // one stored queue entry
   typedef struct packed {
      logic [11:0] rank;
      logic        rank_any;
      logic [15:0] tag;
      logic        tag_any;
      logic [31:0] size;
      logic [31:0] handle;
   } entry_type;

   // command broadcast from the controller to every cell of one queue
   typedef struct packed {
      logic      compare;
      logic      remove;
      logic      append;
      entry_type key;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      FSM_IDLE    = 2'd0,
      FSM_COMPARE = 2'd1,
      FSM_UPDATE  = 2'd2,
      FSM_OUT     = 2'd3
   } fsm_type;

   function automatic logic entry_match(entry_type a, entry_type b);
      logic src_ok;
      logic tag_ok;
      src_ok = a.rank_any | b.rank_any | (a.rank == b.rank);
      tag_ok = a.tag_any | b.tag_any | (a.tag == b.tag);
      return src_ok & tag_ok;
   endfunction

endpackage

>>> hw/rtl/mtm_cell.sv
// one queue slot: holds an entry, compares it to the key, and on a removal
// takes the entry of its younger neighbor, or the key on an append
module mtm_cell
   import mtm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  logic         kill,        // an older cell matched
   input  logic         shift_left,  // removal at or before this slot
   input  logic         append_here,
   input  entry_type    next_entry,
   input  logic         next_valid,
   output entry_type    entry,
   output logic         valid,
   output logic         hit_raw
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      hit_ff,   hit_in;

   // compare result, registered for the priority pass
   always_comb begin
      hit_in = hit_ff;
      if (cmd.compare) begin
         hit_in = valid_ff & entry_match(entry_ff, cmd.key);
      end
   end

   // storage update
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (cmd.remove && shift_left) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end else if (cmd.append && append_here) begin
         entry_in = cmd.key;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry   = entry_ff;
   assign valid   = valid_ff;
   assign hit_raw = hit_ff & ~kill;

endmodule

>>> hw/rtl/mtm_queue.sv
// a chain of cells forming one ordered queue, with first-hit select
module mtm_queue
   import mtm_pkg::*;
#(
   parameter int QueueDepth = QueueDepthDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cell_cmd_type              cmd,
   input  logic [$clog2(QueueDepth+1)-1:0] count,
   output logic                      any_hit,
   output entry_type                 hit_entry,
   output logic [$clog2(QueueDepth+1)-1:0] hit_pos
);

   localparam int CW = $clog2(QueueDepth + 1);

   entry_type                entries [QueueDepth+1];
   logic [QueueDepth:0]      valids;
   logic [QueueDepth-1:0]    hits;
   logic [QueueDepth:0]      seen;   // a hit exists at a lower slot

   assign entries[QueueDepth] = '0;
   assign valids[QueueDepth]  = 1'b0;
   assign seen[0] = 1'b0;

   genvar g;
   generate
      for (g = 0; g < QueueDepth; g++) begin : g_cell
         mtm_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .kill        (seen[g]),
            .shift_left  (seen[g+1]),
            .append_here (count == CW'(g)),
            .next_entry  (entries[g+1]),
            .next_valid  (valids[g+1]),
            .entry       (entries[g]),
            .valid       (valids[g]),
            .hit_raw     (hits[g])
         );
         assign seen[g+1] = seen[g] | hits[g];
      end
   endgenerate

   // pick out the single surviving hit
   always_comb begin
      hit_entry = '0;
      hit_pos   = '0;
      for (int i = 0; i < QueueDepth; i++) begin
         if (hits[i]) begin
            hit_entry = entries[i];
            hit_pos   = CW'(i + 1);
         end
      end
   end

   assign any_hit = seen[QueueDepth];

endmodule

>>> hw/rtl/mpi_tag_matching_engine.sv
// Tag matching engine: each queue is a row of QUEUE_DEPTH cells that compare
// the key in parallel; removal shifts younger entries down one cell, keeping
// order. After a request is accepted, its result beat is formed by the compare
// step, then the priority pick with queue update into the result register,
// independent of queue fill. A new request is taken in the cycle the previous
// result beat leaves, so each request is done before the next one is taken.
module mpi_tag_matching_engine
   import mtm_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   fsm_type   state_ff, state_in;
   req_type   key_ff;
   entry_type key_entry;
   logic [31:0] eager_ff;
   logic [CW-1:0] pcount_ff, pcount_in, ucount_ff, ucount_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   cell_cmd_type pcmd, ucmd;
   logic          p_hit, u_hit;
   entry_type     p_entry, u_entry;
   logic [CW-1:0] p_pos, u_pos;

   logic req_take;
   assign req_take  = req_valid & ~req_stall;
   assign req_stall = (state_ff != FSM_IDLE) | (rsp_valid_ff & rsp_stall);
   assign csr_ready = 1'b1;

   assign key_entry = '{rank: key_ff.peer_rank, rank_any: key_ff.peer_any,
                        tag: key_ff.msg_tag, tag_any: key_ff.tag_any,
                        size: key_ff.msg_size, handle: key_ff.op_handle};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE:    if (req_take) state_in = FSM_COMPARE;
         FSM_COMPARE: state_in = FSM_UPDATE;
         FSM_UPDATE:  state_in = FSM_IDLE;
         default:     state_in = FSM_IDLE;
      endcase
   end

   // search/append results and cell commands
   always_comb begin
      logic          hit;
      entry_type     he;
      logic [CW-1:0] hp;
      logic          full;
      pcmd = '{compare: 1'b0, remove: 1'b0, append: 1'b0, key: key_entry};
      ucmd = pcmd;
      pcount_in    = pcount_ff;
      ucount_in    = ucount_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      hit  = (key_ff.opcode == OP_MSG) ? p_hit : u_hit;
      he   = (key_ff.opcode == OP_MSG) ? p_entry : u_entry;
      hp   = (key_ff.opcode == OP_MSG) ? p_pos : u_pos;
      full = (key_ff.opcode == OP_MSG) ? (ucount_ff == CW'(QUEUE_DEPTH))
                                       : (pcount_ff == CW'(QUEUE_DEPTH));
      case (state_ff)
         FSM_COMPARE: begin
            if (key_ff.opcode == OP_MSG) pcmd.compare = 1'b1;
            else ucmd.compare = 1'b1;
         end
         FSM_UPDATE: begin
            rsp_in       = '0;
            rsp_valid_in = 1'b1;
            if (hit) begin
               rsp_in.status       = ST_MATCHED;
               rsp_in.hit_rank     = he.rank;
               rsp_in.hit_tag      = he.tag;
               rsp_in.hit_size     = he.size;
               rsp_in.hit_handle   = he.handle;
               rsp_in.search_count = 7'(hp);
               rsp_in.rendezvous   = key_ff.msg_size > eager_ff;
               if (key_ff.opcode == OP_MSG) begin
                  pcmd.remove = 1'b1;
                  pcount_in   = pcount_ff - CW'(1);
               end else begin
                  ucmd.remove = 1'b1;
                  ucount_in   = ucount_ff - CW'(1);
               end
            end else if (full) begin
               rsp_in.status = ST_DROPPED;
            end else begin
               rsp_in.status = ST_QUEUED;
               if (key_ff.opcode == OP_MSG) begin
                  ucmd.append = 1'b1;
                  ucount_in   = ucount_ff + CW'(1);
               end else begin
                  pcmd.append = 1'b1;
                  pcount_in   = pcount_ff + CW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   mtm_queue #(.QueueDepth(QUEUE_DEPTH)) u_posted (
      .clock(clock), .reset(reset), .cmd(pcmd), .count(pcount_ff),
      .any_hit(p_hit), .hit_entry(p_entry), .hit_pos(p_pos));

   mtm_queue #(.QueueDepth(QUEUE_DEPTH)) u_unexp (
      .clock(clock), .reset(reset), .cmd(ucmd), .count(ucount_ff),
      .any_hit(u_hit), .hit_entry(u_entry), .hit_pos(u_pos));

   always_ff @(posedge clock) begin
      if (req_take) key_ff <= req_data;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= FSM_IDLE;
         pcount_ff    <= '0;
         ucount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         eager_ff     <= EagerLimitReset;
      end else begin
         state_ff     <= state_in;
         pcount_ff    <= pcount_in;
         ucount_ff    <= ucount_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) eager_ff <= csr_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // counts never exceed the depth
   a_pcount: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= CW'(QUEUE_DEPTH)) else $error("posted count overflow");
   a_ucount: assert property (@(posedge clock) disable iff (reset)
      ucount_ff <= CW'(QUEUE_DEPTH)) else $error("unexpected count overflow");
   // a result beat is produced right after the update step
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_UPDATE |=> rsp_valid_ff) else $error("missing result");
   // counts move only in the update step, so by at most one per item
   a_step: assert property (@(posedge clock) disable iff (reset)
      state_ff != FSM_UPDATE |=> $stable(pcount_ff) && $stable(ucount_ff))
      else $error("count moved outside update");

endmodule

>>> verif/mpi_tag_matching_engine_tb.sv
`timescale 1ns / 100ps

module mpi_tag_matching_engine_tb;
   import mtm_pkg::*;

   localparam int Depth = QueueDepthDefault;
   localparam int IdleLimit = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   mpi_tag_matching_engine #(.QUEUE_DEPTH(Depth)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // matcher shadow state
   entry_type   posted_q[$];
   entry_type   unexp_q[$];
   logic [31:0] eager_limit = EagerLimitReset;
   rsp_type     pending_rsp[$];

   int errors = 0;
   int items_sent = 0;
   int hits_seen = 0;
   int drops_seen = 0;
   int cycle = 0;
   int idle_cycles = 0;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
   endtask

   // search one queue oldest first, remove the hit, else append to the other queue or drop if it is full
   function automatic rsp_type match_item(req_type r);
      rsp_type   o;
      entry_type k;
      int        pos;
      o = '0;
      k = '{rank: r.peer_rank, rank_any: r.peer_any, tag: r.msg_tag,
            tag_any: r.tag_any, size: r.msg_size, handle: r.op_handle};
      pos = -1;
      if (r.opcode == OP_RECV) begin
         foreach (unexp_q[i])
            if (pos < 0 && (k.rank_any || unexp_q[i].rank_any || unexp_q[i].rank == k.rank)
                && (k.tag_any || unexp_q[i].tag_any || unexp_q[i].tag == k.tag))
               pos = i;
      end else begin
         foreach (posted_q[i])
            if (pos < 0 && (k.rank_any || posted_q[i].rank_any || posted_q[i].rank == k.rank)
                && (k.tag_any || posted_q[i].tag_any || posted_q[i].tag == k.tag))
               pos = i;
      end
      if (pos >= 0) begin
         entry_type h;
         h = (r.opcode == OP_RECV) ? unexp_q[pos] : posted_q[pos];
         if (r.opcode == OP_RECV) unexp_q.delete(pos);
         else posted_q.delete(pos);
         o.status = ST_MATCHED;
         o.hit_rank = h.rank;
         o.hit_tag = h.tag;
         o.hit_size = h.size;
         o.hit_handle = h.handle;
         o.search_count = 7'(pos + 1);
         o.rendezvous = (k.size > eager_limit);
      end else if (r.opcode == OP_RECV) begin
         if (posted_q.size() < Depth) begin
            posted_q.insert(posted_q.size(), k);
            o.status = ST_QUEUED;
         end else o.status = ST_DROPPED;
      end else begin
         if (unexp_q.size() < Depth) begin
            unexp_q.insert(unexp_q.size(), k);
            o.status = ST_QUEUED;
         end else o.status = ST_DROPPED;
      end
      return o;
   endfunction

   function automatic req_type mk_req(logic op, logic [11:0] rank, logic pany,
                                      logic [15:0] tag, logic tany,
                                      logic [31:0] size, logic [31:0] handle);
      req_type r;
      r = '{opcode: op, peer_rank: rank, peer_any: pany, msg_tag: tag,
            tag_any: tany, msg_size: size, op_handle: handle};
      return r;
   endfunction

   function automatic rsp_type mk_rsp(status_type st, logic [11:0] rank,
                                      logic [15:0] tag, logic [31:0] size,
                                      logic [31:0] handle, logic [6:0] cnt, logic rdv);
      rsp_type o;
      o = '{status: st, hit_rank: rank, hit_tag: tag, hit_size: size,
            hit_handle: handle, search_count: cnt, rendezvous: rdv};
      return o;
   endfunction

   // sender: hold the beat until accepted, with bursts and gaps
   int burst_left = 0;

   task automatic send(req_type r, bit typed, rsp_type want);
      rsp_type p;
      if (burst_left == 0) begin
         int gap;
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      p = match_item(r);
      pending_rsp.insert(pending_rsp.size(), typed ? want : p);
      items_sent++;
   endtask

   // wait for all results, then let the block settle before a register write
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_limit(logic [31:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      eager_limit = v;
   endtask

   // random beat biased toward small rank and tag pools so that matches occur
   function automatic req_type rand_req(int recv_pct);
      req_type r;
      r.opcode = ($urandom_range(0, 99) < recv_pct) ? OP_RECV : OP_MSG;
      case ($urandom_range(0, 3))
         0: r.peer_rank = 12'hfff;
         1: r.peer_rank = 12'($urandom);
         default: r.peer_rank = 12'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 3))
         0: r.msg_tag = 16'hffff;
         1: r.msg_tag = 16'($urandom);
         default: r.msg_tag = 16'($urandom_range(0, 3));
      endcase
      r.peer_any = ($urandom_range(0, 9) == 0);
      r.tag_any = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 3))
         0: r.msg_size = eager_limit;
         1: r.msg_size = eager_limit + 32'd1;
         default: r.msg_size = $urandom;
      endcase
      r.op_handle = $urandom;
      return r;
   endfunction

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report("result beat with nothing expected", 32'(rsp_data.status), '0);
         end else begin
            rsp_type w;
            w = pending_rsp.pop_front();
            if (rsp_data.status != w.status) report("status", rsp_data.status, w.status);
            if (rsp_data.hit_rank != w.hit_rank) report("hit_rank", rsp_data.hit_rank, w.hit_rank);
            if (rsp_data.hit_tag != w.hit_tag) report("hit_tag", rsp_data.hit_tag, w.hit_tag);
            if (rsp_data.hit_size != w.hit_size) report("hit_size", rsp_data.hit_size, w.hit_size);
            if (rsp_data.hit_handle != w.hit_handle)
               report("hit_handle", rsp_data.hit_handle, w.hit_handle);
            if (rsp_data.search_count != w.search_count)
               report("search_count", rsp_data.search_count, w.search_count);
            if (rsp_data.rendezvous != w.rendezvous)
               report("rendezvous", rsp_data.rendezvous, w.rendezvous);
            if (w.status == ST_MATCHED) hits_seen <= hits_seen + 1;
            if (w.status == ST_DROPPED) drops_seen <= drops_seen + 1;
         end
      end
      case ((cycle / 300) % 3)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 4);
         default: rsp_stall <= (cycle % 8) < 3;
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      if (idle_cycles >= IdleLimit) begin
         $display("timeout: nothing accepted for %0d cycles", IdleLimit);
         $display("FAILURE");
         $finish;
      end
   end

   // stimulus
   req_type dir_req[16];
   rsp_type dir_rsp[16];
   bit      dir_typed[16];

   initial begin
      logic [31:0] limits[4];
      // reset state and extremes with results read off directly
      dir_req[0] = mk_req(OP_RECV, 12'h000, 1'b0, 16'h0000, 1'b0, 32'h0, 32'h0);
      dir_rsp[0] = mk_rsp(ST_QUEUED, '0, '0, '0, '0, '0, 1'b0);
      dir_req[1] = mk_req(OP_MSG, 12'h000, 1'b0, 16'h0000, 1'b0, '1, '1);
      dir_rsp[1] = mk_rsp(ST_MATCHED, '0, '0, '0, '0, 7'd1, 1'b1);
      dir_req[2] = mk_req(OP_MSG, 12'hfff, 1'b0, 16'hffff, 1'b0, 32'd65535, 32'hdead_beef);
      dir_rsp[2] = mk_rsp(ST_QUEUED, '0, '0, '0, '0, '0, 1'b0);
      dir_req[3] = mk_req(OP_RECV, 12'h123, 1'b1, 16'h4567, 1'b1, 32'd65536, 32'h1);
      dir_rsp[3] = mk_rsp(ST_MATCHED, 12'hfff, 16'hffff, 32'd65535, 32'hdead_beef, 7'd1, 1'b1);
      // stored wildcards and ordering
      dir_req[4] = mk_req(OP_RECV, 12'h7, 1'b1, 16'h5, 1'b0, 32'd100, 32'h10);
      dir_req[5] = mk_req(OP_RECV, 12'h7, 1'b0, 16'h9, 1'b1, 32'd65535, 32'h11);
      dir_req[6] = mk_req(OP_RECV, 12'h3, 1'b0, 16'h9, 1'b0, 32'd5, 32'h12);
      dir_req[7] = mk_req(OP_MSG, 12'h3, 1'b0, 16'h9, 1'b0, 32'd65535, 32'h20);
      dir_req[8] = mk_req(OP_MSG, 12'h7, 1'b0, 16'h5, 1'b0, 32'd65536, 32'h21);
      dir_req[9] = mk_req(OP_MSG, 12'h8, 1'b0, 16'h1, 1'b0, 32'd1, 32'h22);
      dir_req[10] = mk_req(OP_MSG, 12'h7, 1'b0, 16'h1, 1'b0, 32'd1, 32'h23);
      dir_req[11] = mk_req(OP_MSG, 12'h8, 1'b0, 16'h2, 1'b1, 32'd2, 32'h24);
      dir_req[12] = mk_req(OP_RECV, 12'h8, 1'b0, 16'h2, 1'b0, 32'd7, 32'h30);
      dir_req[13] = mk_req(OP_RECV, 12'h8, 1'b0, 16'h1, 1'b0, '1, 32'h31);
      dir_req[14] = mk_req(OP_RECV, 12'h0, 1'b1, 16'h0, 1'b1, 32'd0, 32'h32);
      dir_req[15] = mk_req(OP_RECV, 12'h0, 1'b1, 16'h0, 1'b1, 32'd0, 32'h33);
      foreach (dir_typed[i]) dir_typed[i] = (i < 4);
      limits[0] = 32'h0;
      limits[1] = 32'hffff_ffff;
      limits[2] = $urandom;
      limits[3] = EagerLimitReset;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 16; i++) send(dir_req[i], dir_typed[i], dir_rsp[i]);

      // random phases, each under its own eager limit
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         write_limit(limits[ph]);
         // fill both queues to overflow, then mix
         if (ph == 1) begin
            for (int i = 0; i < Depth + 4; i++)
               send(mk_req(OP_RECV, 12'hffe, 1'b0, 16'hfffe, 1'b0, $urandom, $urandom),
                    1'b0, '0);
            for (int i = 0; i < Depth + 4; i++)
               send(mk_req(OP_MSG, 12'hffd, 1'b0, 16'hfffd, 1'b0, $urandom, $urandom),
                    1'b0, '0);
         end
         for (int i = 0; i < 460; i++)
            send(rand_req((ph == 2) ? 70 : (ph == 3) ? 30 : 50), 1'b0, '0);
      end

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d beats: %0d matches, %0d drops, four eager limits incl. 0 and max",
               items_sent, hits_seen, drops_seen);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/mtm_pkg.sv
hw/rtl/mtm_cell.sv
hw/rtl/mtm_queue.sv
hw/rtl/mpi_tag_matching_engine.sv
verif/mpi_tag_matching_engine_tb.sv
